@@ rtl/fprr_pkg.sv @@
// ----------------------------------------------------------------------------
// fprr_pkg
// shared types and constants of the flux pulse rate rescaler
// ----------------------------------------------------------------------------
`default_nettype none

package fprr_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned RADIX_BITS = 2;   // quotient bits per divider cycle
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_MUL = 1'b0,
    CFG_SCALE_DIV = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_IDX,
    ST_LD_IDX,
    ST_DIV_IDX,
    ST_MUL_LEN,
    ST_LD_LEN,
    ST_DIV_LEN,
    ST_FINISH
  } fsm_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] pulse_len;
    logic              index_present;
    logic [DATA_W-1:0] index_offset;
    logic              last_of_track;
  } in_item_t;

  typedef struct packed {
    logic              pulse_valid;
    logic [DATA_W-1:0] scaled_len;
    logic              len_overflow;
    logic              index_valid;
    logic [DATA_W-1:0] index_clock;
    logic              track_end;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DATA_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [DATA_W-1:0]     rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ rtl/fprr_stream_if.sv @@
// ----------------------------------------------------------------------------
// fprr_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface fprr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/fprr_divider.sv @@
// ----------------------------------------------------------------------------
// fprr_divider
// iterative 64-by-32 restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fprr_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fprr_pkg::div_req_t req_i,
  output fprr_pkg::div_res_t      res_o
);

  localparam int unsigned STEPS = fprr_pkg::DIVIDEND_W / fprr_pkg::RADIX_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned DW    = fprr_pkg::DATA_W;
  localparam int unsigned NW    = fprr_pkg::DIVIDEND_W;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    dq_q, dq_d;     // dividend shifts out, quotient shifts in
  logic [DW-1:0]    dvs_q;
  logic [DW:0]      trial;

  // radix-4 step as two chained compare/subtract stages
  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    trial = '0;
    for (int i = 0; i < int'(fprr_pkg::RADIX_BITS); i++) begin
      trial = {rem_d, dq_d[NW-1]};
      dq_d  = {dq_d[NW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial   = trial - {1'b0, dvs_q};
        dq_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
      dq_q  <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = dq_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/flux_pulse_rate_rescaler_unit.sv @@
// ----------------------------------------------------------------------------
// flux_pulse_rate_rescaler_unit
// rescales flux pulse lengths by mul/div with the remainder carried forward
// ----------------------------------------------------------------------------
// sequence: an item with a pulse or an index mark goes from accept through
//   multiply, load, divide and finish to the result register; an item with
//   both does this for the index, then for the pulse; an item with neither
//   goes straight to finish; finish holds for as long as the output register stays full
// throughput: one item at a time, set by the shared 64/32 divider that
//   resolves two quotient bits per cycle; a new item is taken while the
//   previous result still waits in the output register
// reset: asynchronous, active low; scale_mul = scale_div = 1, carried
//   remainder and output clock cleared, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module flux_pulse_rate_rescaler_unit #(
  parameter int unsigned CLOCK_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [fprr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [fprr_pkg::DATA_W-1:0]          cfg_data_i,
  fprr_stream_if.sink                               in_if,
  fprr_stream_if.source                             out_if
);

  localparam int unsigned DW = fprr_pkg::DATA_W;
  localparam int unsigned NW = fprr_pkg::DIVIDEND_W;
  localparam int unsigned CW = CLOCK_WIDTH;

  // configuration registers
  logic [DW-1:0] scale_mul_q;
  logic [DW-1:0] scale_div_q;

  // carried state
  logic [DW-1:0] rem_q;
  logic [CW-1:0] clk_q;

  // sequencer and item registers
  fprr_pkg::fsm_state_e state_q, state_d;
  fprr_pkg::in_item_t   item_q;
  fprr_pkg::in_item_t   in_item;
  logic [NW-1:0]        prod_q;

  // result under construction
  logic          pv_q, ovf_q, iv_q;
  logic [DW-1:0] slen_q;
  logic [CW-1:0] iclk_q;

  // output register
  fprr_pkg::out_item_t out_q;
  logic                out_valid_q;

  // divider
  fprr_pkg::div_req_t div_req;
  fprr_pkg::div_res_t div_res;

  // control strobes
  logic          in_ready;
  logic          mul_en;
  logic          div_start;
  logic          out_load;
  logic          idx_cap;
  logic          len_cap;
  logic          in_accept;
  logic          out_accept;

  logic          in_has_pulse;
  logic          in_do_idx;
  logic [DW-1:0] mul_op;
  logic          len_sat;
  logic [DW-1:0] len_val;

  assign in_item    = in_if.payload;
  assign in_accept  = in_if.valid && in_ready;
  assign out_accept = out_valid_q && out_if.ready;

  // an index mark counts when there is no pulse or it lies inside the pulse
  assign in_has_pulse = (in_item.pulse_len != '0);
  assign in_do_idx    = in_item.index_present &&
                        (!in_has_pulse || (in_item.index_offset < in_item.pulse_len));

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mul_q <= DW'(1);
      scale_div_q <= DW'(1);
    end else if (cfg_we_i) begin
      case (fprr_pkg::cfg_reg_e'(cfg_idx_i))
        fprr_pkg::CFG_SCALE_MUL: scale_mul_q <= cfg_data_i;
        fprr_pkg::CFG_SCALE_DIV: scale_div_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      fprr_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          if (in_do_idx) begin
            state_d = fprr_pkg::ST_MUL_IDX;
          end else if (in_has_pulse) begin
            state_d = fprr_pkg::ST_MUL_LEN;
          end else begin
            state_d = fprr_pkg::ST_FINISH;
          end
        end
      end
      fprr_pkg::ST_MUL_IDX: state_d = fprr_pkg::ST_LD_IDX;
      fprr_pkg::ST_LD_IDX:  state_d = fprr_pkg::ST_DIV_IDX;
      fprr_pkg::ST_DIV_IDX: begin
        if (div_res.done) begin
          state_d = (item_q.pulse_len != '0) ? fprr_pkg::ST_MUL_LEN : fprr_pkg::ST_FINISH;
        end
      end
      fprr_pkg::ST_MUL_LEN: state_d = fprr_pkg::ST_LD_LEN;
      fprr_pkg::ST_LD_LEN:  state_d = fprr_pkg::ST_DIV_LEN;
      fprr_pkg::ST_DIV_LEN: begin
        if (div_res.done) begin
          state_d = fprr_pkg::ST_FINISH;
        end
      end
      fprr_pkg::ST_FINISH: begin
        if (!out_valid_q || out_if.ready) begin
          state_d = fprr_pkg::ST_IDLE;
        end
      end
      default: state_d = fprr_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    idx_cap   = 1'b0;
    len_cap   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      fprr_pkg::ST_IDLE:    in_ready  = 1'b1;
      fprr_pkg::ST_MUL_IDX: mul_en    = 1'b1;
      fprr_pkg::ST_LD_IDX:  div_start = 1'b1;
      fprr_pkg::ST_DIV_IDX: idx_cap   = div_res.done;
      fprr_pkg::ST_MUL_LEN: mul_en    = 1'b1;
      fprr_pkg::ST_LD_LEN:  div_start = 1'b1;
      fprr_pkg::ST_DIV_LEN: len_cap   = div_res.done;
      fprr_pkg::ST_FINISH:  out_load  = !out_valid_q || out_if.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fprr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier, one product per item phase, registered
  // ---------------------------------------------------------------------------
  assign mul_op = (state_q == fprr_pkg::ST_MUL_IDX) ? item_q.index_offset : item_q.pulse_len;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item;
    end
    if (mul_en) begin
      prod_q <= NW'(scale_mul_q) * NW'(mul_op);
    end
  end

  // ---------------------------------------------------------------------------
  // divider request: the pulse division adds in the carried remainder,
  // a zero divisor acts as one
  // ---------------------------------------------------------------------------
  assign div_req.start    = div_start;
  assign div_req.dividend = (state_q == fprr_pkg::ST_LD_LEN) ? (prod_q + NW'(rem_q)) : prod_q;
  assign div_req.divisor  = (scale_div_q == '0) ? DW'(1) : scale_div_q;

  fprr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // quotients above 32 bits saturate
  assign len_sat = (div_res.quot[NW-1:DW] != '0);
  assign len_val = len_sat ? '1 : div_res.quot[DW-1:0];

  // ---------------------------------------------------------------------------
  // result fields of the current item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pv_q   <= in_has_pulse;
      iv_q   <= in_do_idx;
      slen_q <= '0;
      ovf_q  <= 1'b0;
      iclk_q <= '0;
    end else begin
      if (idx_cap) begin
        // index clock is taken before this item's pulse is added
        iclk_q <= clk_q + div_res.quot[CW-1:0];
      end
      if (len_cap) begin
        slen_q <= len_val;
        ovf_q  <= len_sat;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // carried remainder and running output clock, cleared at track end
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      clk_q <= '0;
    end else if (out_load && item_q.last_of_track) begin
      rem_q <= '0;
      clk_q <= '0;
    end else if (len_cap) begin
      rem_q <= div_res.rem;
      clk_q <= clk_q + len_val[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register, frees the sequencer while a result waits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pulse_valid  <= pv_q;
      out_q.scaled_len   <= slen_q;
      out_q.len_overflow <= ovf_q;
      out_q.index_valid  <= iv_q;
      out_q.index_clock  <= DW'(iclk_q);
      out_q.track_end    <= item_q.last_of_track;
    end
  end

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_div_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == fprr_pkg::ST_DIV_IDX || state_q == fprr_pkg::ST_DIV_LEN))
    else $error("divider finished outside a divide phase");

  a_track_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.last_of_track) |=> (rem_q == '0 && clk_q == '0))
    else $error("track end did not clear remainder and clock");

  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.len_overflow) |-> (out_q.pulse_valid && out_q.scaled_len == '1))
    else $error("overflow flag without saturated pulse");

  a_no_pulse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pulse_valid) |-> (!out_q.len_overflow && out_q.scaled_len == '0))
    else $error("empty item carries a pulse length");

  a_no_load_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_if.ready))
    else $error("result register overwritten while full");

endmodule

`default_nettype wire
